// File: hw/rtl/tsms_pkg.sv
// ----------------------------------------------------------------------------
// tsms_pkg: shared constants and helpers for the duration string parser
// Character codes, accumulator widths and saturating arithmetic helpers.
// ----------------------------------------------------------------------------
package tsms_pkg;

    // accumulator and field widths
    localparam int unsigned ACC_W  = 40;
    localparam int unsigned FRAC_W = 10;
    localparam int unsigned OUT_W  = 32;

    // ascii codes
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // scale factors
    localparam logic [ACC_W-1:0] BARE_MS_MIN = 40'd10000;
    localparam logic [9:0]       MS_PER_S    = 10'd1000;
    localparam logic [5:0]       S_PER_MIN   = 6'd60;
    localparam logic [1:0]       FRAC_DIGITS = 2'd3;

    // largest second count whose ms value can still fit in 32 bits
    localparam logic [ACC_W-1:0] MS_SAT_LIMIT = 40'd4294967;

    // a * 60 + b, saturated to the accumulator width
    function automatic logic [ACC_W-1:0] sat_mul60_add(
        input logic [ACC_W-1:0] a,
        input logic [ACC_W-1:0] b
    );
        logic [ACC_W+6:0] s;
        s = {7'd0, a} * {41'd0, S_PER_MIN} + {7'd0, b};
        return (|s[ACC_W+6:ACC_W]) ? {ACC_W{1'b1}} : s[ACC_W-1:0];
    endfunction

    // a * 10 + d, saturated to the accumulator width
    function automatic logic [ACC_W-1:0] sat_mul10_add(
        input logic [ACC_W-1:0] a,
        input logic [3:0]       d
    );
        logic [ACC_W+3:0] s;
        s = {4'd0, a} * 44'd10 + {40'd0, d};
        return (|s[ACC_W+3:ACC_W]) ? {ACC_W{1'b1}} : s[ACC_W-1:0];
    endfunction

endpackage

// File: hw/rtl/time_string_to_ms_parser.sv
// ----------------------------------------------------------------------------
// time_string_to_ms_parser: ascii duration string to milliseconds
// Streams h:m:s[.fff] text one character per request and returns the
// duration in ms, with a well-formed flag, on the end-of-string request.
// ----------------------------------------------------------------------------
// The parser takes one character request per clock cycle while the result
// side does not back up an end request, with the string end marked by
// tlast; the character of the end request is ignored. Each character is held
// in an input register and folded into the parse state in the next cycle
// with one constant multiply-add (x10 for a digit, x60 at a colon). An end
// request then passes a finish stage (segment combine and fraction padding)
// and an output stage (x1000 scaling and 32-bit saturation) on its way to
// the master side; further strings stream in behind it with no gap while the
// result side keeps up. Any malformed or empty string returns 0 with tuser clear.
module time_string_to_ms_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input requests
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] character
    input  logic        i_s_axis_tlast,   // string_end
    // result requests
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] total_ms
    output logic        o_m_axis_tuser    // [0] parse_ok
);

    localparam int unsigned ACC_W  = tsms_pkg::ACC_W;
    localparam int unsigned FRAC_W = tsms_pkg::FRAC_W;
    localparam int unsigned OUT_W  = tsms_pkg::OUT_W;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;

    // parse state
    logic [ACC_W-1:0]  r_seg,  n_seg;
    logic [ACC_W-1:0]  r_tot,  n_tot;
    logic [FRAC_W-1:0] r_frac, n_frac;
    logic [1:0]        r_fcnt, n_fcnt;
    logic r_in_frac, n_in_frac;
    logic r_has_dig, n_has_dig;
    logic r_sep,     n_sep;
    logic r_err,     n_err;
    logic r_any,     n_any;

    // finish stage
    logic              r_a_valid;
    logic [ACC_W-1:0]  r_a_ms,   n_a_ms;
    logic [FRAC_W-1:0] r_a_frac, n_a_frac;
    logic              r_a_bare, n_a_bare;
    logic              r_a_ok,   n_a_ok;

    // output stage
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_ms, n_out_ms;
    logic             r_out_ok;

    logic out_load, a_ready, a_load, in_consume, in_accept;

    // handshake chain
    always_comb begin
        out_load        = r_a_valid && (!r_out_valid || i_m_axis_tready);
        a_ready         = !r_a_valid || out_load;
        in_consume      = r_in_valid && (!r_in_last || a_ready);
        a_load          = in_consume && r_in_last;
        o_s_axis_tready = !r_in_valid || in_consume;
        in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    end

    // character decode and state update
    always_comb begin
        logic [3:0] digit;
        logic       is_digit;
        digit    = 4'(r_in_char - tsms_pkg::CHAR_ZERO);
        is_digit = (r_in_char >= tsms_pkg::CHAR_ZERO) && (r_in_char <= tsms_pkg::CHAR_NINE);

        n_seg     = r_seg;
        n_tot     = r_tot;
        n_frac    = r_frac;
        n_fcnt    = r_fcnt;
        n_in_frac = r_in_frac;
        n_has_dig = r_has_dig;
        n_sep     = r_sep;
        n_err     = r_err;
        n_any     = 1'b1;

        if (!r_err) begin
            if (r_in_char == tsms_pkg::CHAR_COLON) begin
                if (r_in_frac || !r_has_dig) begin
                    n_err = 1'b1;
                end else begin
                    n_tot     = tsms_pkg::sat_mul60_add(r_tot, r_seg);
                    n_seg     = '0;
                    n_has_dig = 1'b0;
                    n_sep     = 1'b1;
                end
            end else if (r_in_char == tsms_pkg::CHAR_DOT
                      || r_in_char == tsms_pkg::CHAR_COMMA) begin
                if (r_in_frac) begin
                    n_err = 1'b1;
                end else begin
                    n_in_frac = 1'b1;
                    n_sep     = 1'b1;
                end
            end else if (is_digit) begin
                n_has_dig = 1'b1;
                if (!r_in_frac) begin
                    n_seg = tsms_pkg::sat_mul10_add(r_seg, digit);
                end else if (r_fcnt < tsms_pkg::FRAC_DIGITS) begin
                    n_frac = FRAC_W'(r_frac * 4'd10 + {6'd0, digit});
                    n_fcnt = r_fcnt + 2'd1;
                end
            end else begin
                n_err = 1'b1;
            end
        end
    end

    // finish: combine segments and pad the fraction to ms
    always_comb begin
        n_a_ok   = r_any && !r_err && r_has_dig;
        n_a_bare = 1'b0;
        n_a_frac = '0;
        if (!r_sep) begin
            n_a_ms   = r_seg;
            n_a_bare = (r_seg >= tsms_pkg::BARE_MS_MIN);
        end else begin
            n_a_ms = tsms_pkg::sat_mul60_add(r_tot, r_seg);
            case (r_fcnt)
                2'd1:    n_a_frac = FRAC_W'(r_frac * 7'd100);
                2'd2:    n_a_frac = FRAC_W'(r_frac * 4'd10);
                2'd3:    n_a_frac = r_frac;
                default: n_a_frac = '0;
            endcase
        end
    end

    // output: scale seconds to ms (bare ms values pass through) and saturate to 32 bits
    always_comb begin
        logic [OUT_W:0] prod;
        prod = {10'd0, r_a_ms[22:0]} * {23'd0, tsms_pkg::MS_PER_S} + {23'd0, r_a_frac};
        if (!r_a_ok) begin
            n_out_ms = '0;
        end else if (r_a_bare) begin
            n_out_ms = (|r_a_ms[ACC_W-1:OUT_W]) ? {OUT_W{1'b1}} : r_a_ms[OUT_W-1:0];
        end else if (r_a_ms > tsms_pkg::MS_SAT_LIMIT || prod[OUT_W]) begin
            n_out_ms = {OUT_W{1'b1}};
        end else begin
            n_out_ms = prod[OUT_W-1:0];
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (in_consume) begin
            r_in_valid <= 1'b0;
        end
        if (in_accept) begin
            r_in_char <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    // parse state, cleared after every string end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || a_load) begin
            r_seg     <= '0;
            r_tot     <= '0;
            r_frac    <= '0;
            r_fcnt    <= '0;
            r_in_frac <= 1'b0;
            r_has_dig <= 1'b0;
            r_sep     <= 1'b0;
            r_err     <= 1'b0;
            r_any     <= 1'b0;
        end else if (in_consume) begin
            r_seg     <= n_seg;
            r_tot     <= n_tot;
            r_frac    <= n_frac;
            r_fcnt    <= n_fcnt;
            r_in_frac <= n_in_frac;
            r_has_dig <= n_has_dig;
            r_sep     <= n_sep;
            r_err     <= n_err;
            r_any     <= n_any;
        end
    end

    // finish stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_load) begin
            r_a_valid <= 1'b1;
        end else if (out_load) begin
            r_a_valid <= 1'b0;
        end
        if (a_load) begin
            r_a_ms   <= n_a_ms;
            r_a_frac <= n_a_frac;
            r_a_bare <= n_a_bare;
            r_a_ok   <= n_a_ok;
        end
    end

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out_ms <= n_out_ms;
            r_out_ok <= r_a_ok;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_ms;
    assign o_m_axis_tuser  = r_out_ok;

endmodule

// File: verif/tsms_checker.sv
// ----------------------------------------------------------------------------
// tsms_checker: result predictor and scoreboard for the duration parser
// Watches the character and result streams, rebuilds the parse state on
// every accepted character request and checks each result request in order.
// ----------------------------------------------------------------------------
module tsms_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // character side
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [7:0]                  i_in_data,
    input  logic                        i_in_last,
    // result side
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [tsms_pkg::OUT_W-1:0]  i_out_data,
    input  logic                        i_out_user,
    // status for the test top
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_ok_count
);

    localparam int ACC_W     = tsms_pkg::ACC_W;
    localparam int FRAC_W    = tsms_pkg::FRAC_W;
    localparam int OUT_W     = tsms_pkg::OUT_W;
    localparam int FRAC_KEEP = 3;

    typedef struct packed {
        logic [OUT_W-1:0] ms;
        logic             ok;
    } t_duration;

    // durations still owed by the parser, oldest first
    t_duration durations_due[$];

    // parse state of the string in flight
    logic [ACC_W-1:0]  seg_secs;
    logic [ACC_W-1:0]  total_secs;
    logic [FRAC_W-1:0] frac_ms;
    logic [1:0]        frac_digits;
    logic              in_frac;
    logic              seg_digit;
    logic              sep_seen;
    logic              bad;
    logic              nonempty;

    int n_fail = 0;
    int n_ok   = 0;

    // saturate a wide value to the accumulator width
    function automatic logic [ACC_W-1:0] clip40(input logic [63:0] v);
        return (|v[63:ACC_W]) ? {ACC_W{1'b1}} : v[ACC_W-1:0];
    endfunction

    // saturate a wide value to the result width
    function automatic logic [OUT_W-1:0] clip32(input logic [63:0] v);
        return (|v[63:OUT_W]) ? {OUT_W{1'b1}} : v[OUT_W-1:0];
    endfunction

    task automatic clear_parse();
        seg_secs    = '0;
        total_secs  = '0;
        frac_ms     = '0;
        frac_digits = '0;
        in_frac     = 1'b0;
        seg_digit   = 1'b0;
        sep_seen    = 1'b0;
        bad         = 1'b0;
        nonempty    = 1'b0;
    endtask

    // fold one character into the parse state
    task automatic feed_char(input logic [7:0] ch);
        logic [3:0] digit;
        digit    = ch[3:0] - tsms_pkg::CHAR_ZERO[3:0];
        nonempty = 1'b1;
        if (!bad) begin
            if (ch == tsms_pkg::CHAR_COLON) begin
                // a colon closes an integer segment that holds a digit
                if (in_frac || !seg_digit) begin
                    bad = 1'b1;
                end else begin
                    total_secs = clip40({24'd0, total_secs} * 64'd60 + {24'd0, seg_secs});
                    seg_secs   = '0;
                    seg_digit  = 1'b0;
                    sep_seen   = 1'b1;
                end
            end else if (ch == tsms_pkg::CHAR_DOT || ch == tsms_pkg::CHAR_COMMA) begin
                if (in_frac) begin
                    bad = 1'b1;
                end else begin
                    in_frac  = 1'b1;
                    sep_seen = 1'b1;
                end
            end else if (ch >= tsms_pkg::CHAR_ZERO && ch <= tsms_pkg::CHAR_NINE) begin
                seg_digit = 1'b1;
                if (!in_frac) begin
                    seg_secs = clip40({24'd0, seg_secs} * 64'd10 + {60'd0, digit});
                end else if (frac_digits < 2'(FRAC_KEEP)) begin
                    // digits past the third are dropped
                    frac_ms     = frac_ms * 10'd10 + {6'd0, digit};
                    frac_digits = frac_digits + 2'd1;
                end
            end else begin
                bad = 1'b1;
            end
        end
    endtask

    // duration owed for the string closed by an end request
    function automatic t_duration close_string();
        t_duration        r;
        logic [63:0]      full;
        logic [OUT_W-1:0] pad;
        int               n;
        r = '0;
        if (nonempty && !bad && seg_digit) begin
            r.ok = 1'b1;
            if (!sep_seen) begin
                // bare number: ms from 10000 up, seconds below
                full = {24'd0, seg_secs};
                if (full < 64'd10000)
                    full = full * 64'd1000;
                r.ms = clip32(full);
            end else begin
                full = {24'd0, clip40({24'd0, total_secs} * 64'd60 + {24'd0, seg_secs})};
                pad  = {22'd0, frac_ms};
                for (n = frac_digits; n < FRAC_KEEP; n++)
                    pad = pad * 32'd10;
                r.ms = clip32(full * 64'd1000 + {32'd0, pad});
            end
        end
        return r;
    endfunction

    // compare results, then track the incoming characters
    always @(posedge i_clk) begin
        t_duration due;
        if (!i_rst_n) begin
            clear_parse();
            durations_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (durations_due.size() == 0) begin
                    $error("unexpected result: total_ms %0d parse_ok %0b",
                           i_out_data, i_out_user);
                    n_fail++;
                end else begin
                    due = durations_due.pop_front();
                    if (i_out_data !== due.ms) begin
                        $error("total_ms: expected %0d, actual %0d", due.ms, i_out_data);
                        n_fail++;
                    end
                    if (i_out_user !== due.ok) begin
                        $error("parse_ok: expected %0b, actual %0b", due.ok, i_out_user);
                        n_fail++;
                    end
                    if (due.ok)
                        n_ok++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_last) begin
                    durations_due.push_back(close_string());
                    clear_parse();
                end else begin
                    feed_char(i_in_data);
                end
            end
        end
        o_fail_count <= n_fail;
        o_pending    <= durations_due.size();
        o_ok_count   <= n_ok;
    end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: test top for the duration string parser
// Streams directed and random duration strings with random gaps on both
// sides; the checker beside the parser predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

    localparam int ITEM_TARGET  = 1350;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 7;
    localparam int DRAIN_CYCLES = 12;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic [7:0]                 in_data   = '0;
    logic                       in_last   = 1'b0;
    logic                       out_ready = 1'b0;
    logic                       calm      = 1'b0;
    logic                       in_ready;
    logic                       out_valid;
    logic [tsms_pkg::OUT_W-1:0] out_data;
    logic                       out_user;

    int fail_count;
    int pending;
    int ok_count;
    int items_sent   = 0;
    int strings_sent = 0;
    int cycles       = 0;

    // characters of the next string
    logic [7:0] text[$];

    always #10 clk = ~clk;

    time_string_to_ms_parser u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .i_s_axis_tlast  (in_last),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data),
        .o_m_axis_tuser  (out_user)
    );

    tsms_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_in_last    (in_last),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_out_user   (out_user),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_ok_count   (ok_count)
    );

    // result-side stalls
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one request, after an optional gap, held until accepted
    task automatic send_char(input logic [7:0] ch, input logic last);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ch;
        in_last  <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // the buffered string, then its end request with a junk character
    task automatic send_text();
        foreach (text[i])
            send_char(text[i], 1'b0);
        send_char(8'($urandom_range(255)), 1'b1);
        strings_sent++;
    endtask

    // hold off until every owed result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
    endtask

    task automatic add_digits(input int n);
        repeat (n) text.push_back(tsms_pkg::CHAR_ZERO + 8'($urandom_range(9)));
    endtask

    // segment length: mostly short, some long enough to saturate
    function automatic int seg_len();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 7);
        return $urandom_range(8, 15);
    endfunction

    // well-formed h:m:s style string with an optional fraction
    task automatic make_good();
        int nseg;
        int nfrac;
        text.delete();
        nseg = $urandom_range(1, 4);
        for (int i = 0; i < nseg; i++) begin
            if (i > 0)
                text.push_back(tsms_pkg::CHAR_COLON);
            // bare numbers near the ms threshold
            if (nseg == 1 && $urandom_range(3) == 0)
                add_digits($urandom_range(4, 5));
            else
                add_digits(seg_len());
        end
        if ($urandom_range(1)) begin
            // fraction with no integer part now and then
            if (nseg == 1 && $urandom_range(5) == 0)
                text.delete();
            text.push_back($urandom_range(1) ? tsms_pkg::CHAR_DOT : tsms_pkg::CHAR_COMMA);
            nfrac = $urandom_range(0, 5);
            if (text.size() == 1 && nfrac == 0)
                nfrac = 1;
            add_digits(nfrac);
        end
    endtask

    // well-formed string with one inserted, appended or replaced character, usually a defect
    task automatic make_broken();
        int pos;
        make_good();
        pos = $urandom_range(text.size());
        case ($urandom_range(4))
            0: text.insert(pos, tsms_pkg::CHAR_COLON);
            1: text.insert(pos, $urandom_range(1) ? tsms_pkg::CHAR_DOT : tsms_pkg::CHAR_COMMA);
            2: text.insert(pos, 8'($urandom_range(1, 255)));
            3: text.push_back(tsms_pkg::CHAR_COLON);
            default: begin
                if (pos == text.size())
                    text.push_back(8'($urandom_range(1, 255)));
                else
                    text[pos] = 8'($urandom_range(1, 255));
            end
        endcase
    endtask

    // arbitrary bytes, possibly none
    task automatic make_noise();
        text.delete();
        repeat ($urandom_range(0, 6)) text.push_back(8'($urandom_range(1, 255)));
    endtask

    initial begin
        int pick;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed strings: empty, bare seconds and ms, fractions
        text.delete();
        send_text();
        text.delete(); add_str("9999");  send_text();
        text.delete(); add_str("10000"); send_text();
        text.delete(); add_str("1:2.5"); send_text();
        text.delete(); add_str("5.");    send_text();
        text.delete(); add_str(",1234"); send_text();
        drain();

        // random strings, with a quiet stretch and one full drain midway
        while (items_sent < ITEM_TARGET) begin
            calm <= (items_sent >= 500 && items_sent < 800);
            if (strings_sent == 80)
                drain();
            pick = $urandom_range(99);
            if (pick < 70)
                make_good();
            else if (pick < 88)
                make_broken();
            else
                make_noise();
            send_text();
        end
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d strings over %0d requests, %0d results well formed",
                 strings_sent, items_sent, ok_count);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
